FILE: design/spp_pkg.sv
// Package for the sprite perspective projection block.
// Holds register widths, reset values, register indexes, divider sizes
// and the structs that travel beside the divider pipelines.
`default_nettype none

package spp_pkg;

    localparam int ANGLE_BITS_DEF = 12;

    localparam logic [11:0] SCREEN_W_RST = 12'd800;
    localparam logic [11:0] SCREEN_H_RST = 12'd600;
    localparam logic [17:0] FOCAL_RST    = 18'd177362;
    localparam logic [9:0]  GAIN_RST     = 10'd300;
    localparam logic [15:0] NEAR_RST     = 16'd26;

    localparam logic [14:0] SIN_ONE = 15'd16384;
    localparam logic [15:0] SIN_CA  = 16'd51472;
    localparam logic [14:0] SIN_CB  = 15'd21024;
    localparam logic [11:0] SIN_CC  = 12'd2320;

    localparam int XDIV_NW = 62;
    localparam int XDIV_DW = 46;
    localparam int SDIV_DW = 42;
    localparam int KDIV_NW = 28;
    localparam int KDIV_DW = 12;

    typedef enum logic [2:0] {
        CFG_SCREEN_W = 3'd0,
        CFG_SCREEN_H = 3'd1,
        CFG_FOCAL    = 3'd2,
        CFG_GAIN     = 3'd3,
        CFG_NEAR     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0]        hs;
        logic signed [15:0] pt;
        logic [11:0]        tw;
        logic [11:0]        th;
    } t_carry;

    typedef struct packed {
        logic               vis;
        logic               neg;
        logic signed [15:0] pt;
        logic [11:0]        tw;
        logic [11:0]        th;
    } t_side_a;

    typedef struct packed {
        logic               vis;
        logic               sv;
        logic               satx;
        logic               saty;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        size;
    } t_side_b;

endpackage

`default_nettype wire

FILE: design/spp_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// No package dependency.
`default_nettype none

module spp_div #(
    parameter int NW = 8,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_den [NW];
    logic [DW-1:0] n_rem [NW];
    logic [NW-1:0] n_nq  [NW];
    logic [DW-1:0] n_den [NW];

    always_comb begin
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                rem_in   = '0;
                nq_in    = i_num;
                n_den[k] = i_den;
            end else begin
                rem_in   = r_rem[k-1];
                nq_in    = r_nq[k-1];
                n_den[k] = r_den[k-1];
            end
            trial = {rem_in, nq_in[NW-1]};
            diff  = trial - {1'b0, n_den[k]};
            if (trial >= {1'b0, n_den[k]}) begin
                n_rem[k] = diff[DW-1:0];
                n_nq[k]  = {nq_in[NW-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[DW-1:0];
                n_nq[k]  = {nq_in[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_nq[NW-1];

endmodule

`default_nettype wire

FILE: design/sprite_perspective_projection_top.sv
// Billboard sprite projection: one request in and one result out per clock.
// The pipeline has nine front stages (relative position, sine polynomial,
// rotation, focal product), 62 stages of the bit-per-stage position and size
// dividers, two combine stages, 28 stages of the texture scale dividers and the
// output register. The whole pipeline holds while the output register is full
// and not taken. Uses spp_pkg and spp_div.
`default_nettype none

module sprite_perspective_projection_top import spp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [23:0] i_object_x,
    input  wire logic signed [23:0] i_object_y,
    input  wire logic [11:0]        i_object_scale,
    input  wire logic [11:0]        i_texture_width,
    input  wire logic [11:0]        i_texture_height,
    input  wire logic signed [23:0] i_camera_x,
    input  wire logic signed [23:0] i_camera_y,
    input  wire logic [11:0]        i_camera_angle,
    input  wire logic signed [15:0] i_camera_pitch,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_visible,
    output logic signed [15:0]      o_sprite_left,
    output logic signed [15:0]      o_sprite_top,
    output logic [15:0]             o_sprite_size,
    output logic                    o_scale_valid,
    output logic [15:0]             o_scale_x,
    output logic [15:0]             o_scale_y,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [17:0]        i_cfg_data
);

    logic        en;
    logic [11:0] r_screen_w;
    logic [11:0] r_screen_h;
    logic [17:0] r_focal;
    logic [9:0]  r_gain;
    logic [15:0] r_near;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_W_RST;
            r_screen_h <= SCREEN_H_RST;
            r_focal    <= FOCAL_RST;
            r_gain     <= GAIN_RST;
            r_near     <= NEAR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCREEN_W: r_screen_w <= i_cfg_data[11:0];
                CFG_SCREEN_H: r_screen_h <= i_cfg_data[11:0];
                CFG_FOCAL:    r_focal    <= i_cfg_data;
                CFG_GAIN:     r_gain     <= i_cfg_data[9:0];
                CFG_NEAR:     r_near     <= i_cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    function automatic logic [15:0] ang_split(input logic [ANGLE_BITS-1:0] a);
        logic [13:0] x14;
        logic [14:0] x15;
        x14 = 14'(a[ANGLE_BITS-3:0]) << (16 - ANGLE_BITS);
        x15 = a[ANGLE_BITS-2] ? (SIN_ONE - {1'b0, x14}) : {1'b0, x14};
        return {a[ANGLE_BITS-1], x15};
    endfunction

    // stage A: relative position, angle split, size numerator, pitch shift
    logic [ANGLE_BITS-1:0] ang_s, ang_c;
    logic [15:0]           spl_s, spl_c;
    logic signed [26:0]    pitch_prod;
    t_carry                n_a_cr;

    assign ang_s = ANGLE_BITS'(0) - ANGLE_BITS'(i_camera_angle);
    assign ang_c = ang_s + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
    assign spl_s = ang_split(ang_s);
    assign spl_c = ang_split(ang_c);
    assign pitch_prod = i_camera_pitch * $signed({1'b0, r_gain});

    always_comb begin
        n_a_cr.hs = r_screen_h * i_object_scale;
        n_a_cr.pt = 16'(pitch_prod >>> 10);
        n_a_cr.tw = i_texture_width;
        n_a_cr.th = i_texture_height;
    end

    logic               r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    logic               r_f_vld, r_g_vld, r_h_vld, r_i_vld;
    logic signed [24:0] r_a_rx, r_a_ry, r_b_rx, r_b_ry, r_c_rx, r_c_ry;
    logic signed [24:0] r_d_rx, r_d_ry, r_e_rx, r_e_ry;
    logic [14:0]        r_a_xs, r_a_xc, r_b_xs, r_b_xc, r_c_xs, r_c_xc, r_d_xs, r_d_xc;
    logic               r_a_ns, r_a_nc, r_b_ns, r_b_nc, r_c_ns, r_c_nc, r_d_ns, r_d_nc;
    logic [14:0]        r_b_x2s, r_b_x2c, r_c_x2s, r_c_x2c;
    logic [14:0]        r_c_t1s, r_c_t1c;
    logic [15:0]        r_d_t2s, r_d_t2c;
    logic signed [16:0] r_e_sn, r_e_cs;
    logic signed [41:0] r_f_p0, r_f_p1, r_f_p2, r_f_p3;
    logic signed [42:0] r_g_d, r_g_e;
    logic               r_h_vis;
    logic [41:0]        r_h_d;
    logic signed [61:0] r_h_ef;
    logic               r_i_vis, r_i_neg;
    logic [61:0]        r_i_na;
    logic [45:0]        r_i_den;
    logic [61:0]        r_i_snum;
    logic [41:0]        r_i_sden;
    t_carry             r_a_cr, r_b_cr, r_c_cr, r_d_cr, r_e_cr, r_f_cr, r_g_cr, r_h_cr, r_i_cr;

    // sine polynomial pieces
    logic [29:0] x2s_p, x2c_p, t2s_p, t2c_p;
    logic [26:0] t1s_p, t1c_p;
    logic [30:0] ss_p, sc_p;
    logic [15:0] ss_m, sc_m;

    assign x2s_p = r_a_xs * r_a_xs;
    assign x2c_p = r_a_xc * r_a_xc;
    assign t1s_p = r_b_x2s * SIN_CC;
    assign t1c_p = r_b_x2c * SIN_CC;
    assign t2s_p = r_c_x2s * r_c_t1s;
    assign t2c_p = r_c_x2c * r_c_t1c;
    assign ss_p  = r_d_xs * r_d_t2s;
    assign sc_p  = r_d_xc * r_d_t2c;
    assign ss_m  = ss_p[30:15];
    assign sc_m  = sc_p[30:15];

    logic signed [18:0] foc_s;
    assign foc_s = $signed({1'b0, r_focal});

    // front pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rx  <= 25'(i_object_x) - 25'(i_camera_x);
            r_a_ry  <= 25'(i_object_y) - 25'(i_camera_y);
            r_a_xs  <= spl_s[14:0];
            r_a_xc  <= spl_c[14:0];
            r_a_ns  <= spl_s[15];
            r_a_nc  <= spl_c[15];
            r_a_cr  <= n_a_cr;

            r_b_rx  <= r_a_rx;
            r_b_ry  <= r_a_ry;
            r_b_xs  <= r_a_xs;
            r_b_xc  <= r_a_xc;
            r_b_ns  <= r_a_ns;
            r_b_nc  <= r_a_nc;
            r_b_x2s <= x2s_p[28:14];
            r_b_x2c <= x2c_p[28:14];
            r_b_cr  <= r_a_cr;

            r_c_rx  <= r_b_rx;
            r_c_ry  <= r_b_ry;
            r_c_xs  <= r_b_xs;
            r_c_xc  <= r_b_xc;
            r_c_ns  <= r_b_ns;
            r_c_nc  <= r_b_nc;
            r_c_x2s <= r_b_x2s;
            r_c_x2c <= r_b_x2c;
            r_c_t1s <= SIN_CB - {2'b00, t1s_p[26:14]};
            r_c_t1c <= SIN_CB - {2'b00, t1c_p[26:14]};
            r_c_cr  <= r_b_cr;

            r_d_rx  <= r_c_rx;
            r_d_ry  <= r_c_ry;
            r_d_xs  <= r_c_xs;
            r_d_xc  <= r_c_xc;
            r_d_ns  <= r_c_ns;
            r_d_nc  <= r_c_nc;
            r_d_t2s <= SIN_CA - t2s_p[29:14];
            r_d_t2c <= SIN_CA - t2c_p[29:14];
            r_d_cr  <= r_c_cr;

            r_e_rx  <= r_d_rx;
            r_e_ry  <= r_d_ry;
            r_e_sn  <= r_d_ns ? -$signed({1'b0, ss_m}) : $signed({1'b0, ss_m});
            r_e_cs  <= r_d_nc ? -$signed({1'b0, sc_m}) : $signed({1'b0, sc_m});
            r_e_cr  <= r_d_cr;

            r_f_p0  <= 42'(r_e_rx) * 42'(r_e_cs);
            r_f_p1  <= 42'(r_e_ry) * 42'(r_e_sn);
            r_f_p2  <= 42'(r_e_rx) * 42'(r_e_sn);
            r_f_p3  <= 42'(r_e_ry) * 42'(r_e_cs);
            r_f_cr  <= r_e_cr;

            r_g_d   <= 43'(r_f_p0) - 43'(r_f_p1);
            r_g_e   <= 43'(r_f_p2) + 43'(r_f_p3);
            r_g_cr  <= r_f_cr;

            r_h_vis <= r_g_d > $signed(43'({r_near, 14'd0}));
            r_h_d   <= r_g_d[41:0];
            r_h_ef  <= r_g_e * foc_s;
            r_h_cr  <= r_g_cr;

            r_i_vis  <= r_h_vis;
            r_i_neg  <= r_h_ef[61];
            r_i_na   <= r_h_ef[61]
                        ? (62'(-r_h_ef) + 62'({r_h_d, 4'd0}) - 62'd1)
                        : 62'(r_h_ef);
            r_i_den  <= {r_h_d, 4'd0};
            r_i_snum <= 62'({r_h_cr.hs, 18'd0});
            r_i_sden <= r_h_d;
            r_i_cr   <= r_h_cr;
        end
    end

    // position and size dividers
    logic [XDIV_NW-1:0] qx, qs;
    logic               r_va [XDIV_NW];
    t_side_a            r_sa [XDIV_NW];

    spp_div #(.NW(XDIV_NW), .DW(XDIV_DW)) u_xdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_i_na),
        .i_den (r_i_den),
        .o_quo (qx)
    );

    spp_div #(.NW(XDIV_NW), .DW(SDIV_DW)) u_sdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_i_snum),
        .i_den (r_i_sden),
        .o_quo (qs)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa[0] <= '{vis: r_i_vis, neg: r_i_neg, pt: r_i_cr.pt,
                         tw: r_i_cr.tw, th: r_i_cr.th};
            for (int k = 1; k < XDIV_NW; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
        end
    end

    // combine stages J and K
    t_side_a            sa_o;
    logic [41:0]        size_w;
    logic [40:0]        half_w;
    logic signed [62:0] q_w;
    logic [45:0]        sz16_w;

    assign sa_o   = r_sa[XDIV_NW-1];
    assign size_w = qs[41:0];
    assign half_w = size_w[41:1];
    assign q_w    = sa_o.neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign sz16_w = {size_w, 4'd0};

    logic               r_j_vld, r_j_vis, r_j_sv, r_j_satx, r_j_saty;
    logic signed [63:0] r_j_left;
    logic signed [43:0] r_j_top;
    logic [41:0]        r_j_size;

    logic               r_k_vld;
    t_side_b            r_k_sb;
    logic [KDIV_NW-1:0] r_k_nx, r_k_ny;
    logic [11:0]        r_k_tw, r_k_th;
    logic [11:0]        r_j_tw, r_j_th;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_vis  <= sa_o.vis;
            r_j_sv   <= (sa_o.tw != 12'd0) && (sa_o.th != 12'd0);
            r_j_satx <= sz16_w >= 46'({sa_o.tw, 16'd0});
            r_j_saty <= sz16_w >= 46'({sa_o.th, 16'd0});
            r_j_left <= $signed(64'({r_screen_w, 3'd0})) + 64'(q_w)
                        - $signed(64'(half_w));
            r_j_top  <= $signed(44'({r_screen_h, 3'd0})) + 44'(sa_o.pt)
                        - $signed(44'(half_w));
            r_j_size <= size_w;
            r_j_tw   <= sa_o.tw;
            r_j_th   <= sa_o.th;

            r_k_sb.vis  <= r_j_vis;
            r_k_sb.sv   <= r_j_sv;
            r_k_sb.satx <= r_j_satx;
            r_k_sb.saty <= r_j_saty;
            if (r_j_left > 64'sd32767) begin
                r_k_sb.left <= 16'sh7FFF;
            end else if (r_j_left < -64'sd32768) begin
                r_k_sb.left <= 16'sh8000;
            end else begin
                r_k_sb.left <= 16'(r_j_left);
            end
            if (r_j_top > 44'sd32767) begin
                r_k_sb.top <= 16'sh7FFF;
            end else if (r_j_top < -44'sd32768) begin
                r_k_sb.top <= 16'sh8000;
            end else begin
                r_k_sb.top <= 16'(r_j_top);
            end
            r_k_sb.size <= (r_j_size > 42'd65535) ? 16'hFFFF : r_j_size[15:0];
            r_k_nx      <= {r_j_size[23:0], 4'd0};
            r_k_ny      <= {r_j_size[23:0], 4'd0};
            r_k_tw      <= r_j_tw;
            r_k_th      <= r_j_th;
        end
    end

    // texture scale dividers
    logic [KDIV_NW-1:0] kx, ky;
    logic               r_vb [KDIV_NW];
    t_side_b            r_sb [KDIV_NW];

    spp_div #(.NW(KDIV_NW), .DW(KDIV_DW)) u_kxdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_k_nx),
        .i_den (r_k_tw),
        .o_quo (kx)
    );

    spp_div #(.NW(KDIV_NW), .DW(KDIV_DW)) u_kydiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_k_ny),
        .i_den (r_k_th),
        .o_quo (ky)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= r_k_sb;
            for (int k = 1; k < KDIV_NW; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // output register
    t_side_b            sb_o;
    logic               r_l_vld;
    logic               r_l_vis, r_l_sv;
    logic signed [15:0] r_l_left, r_l_top;
    logic [15:0]        r_l_size, r_l_sx, r_l_sy;

    assign sb_o = r_sb[KDIV_NW-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_vis  <= sb_o.vis;
            r_l_left <= sb_o.vis ? sb_o.left : 16'sd0;
            r_l_top  <= sb_o.vis ? sb_o.top : 16'sd0;
            r_l_size <= sb_o.vis ? sb_o.size : 16'd0;
            r_l_sv   <= sb_o.vis && sb_o.sv;
            if (sb_o.vis && sb_o.sv) begin
                r_l_sx <= sb_o.satx ? 16'hFFFF : kx[15:0];
                r_l_sy <= sb_o.saty ? 16'hFFFF : ky[15:0];
            end else begin
                r_l_sx <= 16'd0;
                r_l_sy <= 16'd0;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            for (int k = 0; k < XDIV_NW; k++) begin
                r_va[k] <= 1'b0;
            end
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
            for (int k = 0; k < KDIV_NW; k++) begin
                r_vb[k] <= 1'b0;
            end
            r_l_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_va[0] <= r_i_vld;
            for (int k = 1; k < XDIV_NW; k++) begin
                r_va[k] <= r_va[k-1];
            end
            r_j_vld <= r_va[XDIV_NW-1];
            r_k_vld <= r_j_vld;
            r_vb[0] <= r_k_vld;
            for (int k = 1; k < KDIV_NW; k++) begin
                r_vb[k] <= r_vb[k-1];
            end
            r_l_vld <= r_vb[KDIV_NW-1];
        end
    end

    // hold everything while the result waits
    assign en          = !r_l_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_l_vld;

    assign o_visible     = r_l_vis;
    assign o_sprite_left = r_l_left;
    assign o_sprite_top  = r_l_top;
    assign o_sprite_size = r_l_size;
    assign o_scale_valid = r_l_sv;
    assign o_scale_x     = r_l_sx;
    assign o_scale_y     = r_l_sy;

endmodule

`default_nettype wire

FILE: design/spp_checker.sv
// Port-level checker for the sprite projection top level, with its bind.
// Depends only on the top level's ports.
`default_nettype none

module spp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic signed [23:0] i_object_x,
    input wire logic signed [23:0] i_object_y,
    input wire logic [11:0]        i_object_scale,
    input wire logic [11:0]        i_texture_width,
    input wire logic [11:0]        i_texture_height,
    input wire logic signed [23:0] i_camera_x,
    input wire logic signed [23:0] i_camera_y,
    input wire logic [11:0]        i_camera_angle,
    input wire logic signed [15:0] i_camera_pitch,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_visible,
    input wire logic signed [15:0] o_sprite_left,
    input wire logic signed [15:0] o_sprite_top,
    input wire logic [15:0]        o_sprite_size,
    input wire logic               o_scale_valid,
    input wire logic [15:0]        o_scale_x,
    input wire logic [15:0]        o_scale_y,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready,
    input wire logic [2:0]         i_cfg_index,
    input wire logic [17:0]        i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sprite_left)
            && $stable(o_sprite_top) && $stable(o_sprite_size)
            && $stable(o_scale_x) && $stable(o_scale_y))
        else $error("result dropped or changed while stalled");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_visible |-> o_sprite_left == 16'sd0
            && o_sprite_top == 16'sd0 && o_sprite_size == 16'd0 && !o_scale_valid)
        else $error("hidden sprite carries nonzero fields");

    a_no_texture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_scale_valid |-> o_scale_x == 16'd0 && o_scale_y == 16'd0)
        else $error("scale factors set without texture");

    a_scale_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scale_valid |-> o_visible)
        else $error("scale valid on hidden sprite");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind sprite_perspective_projection_top spp_checker u_spp_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for sprite_perspective_projection_top: directed and random
// projection requests, register rewrites between phases, random stalls on both sides.
// Depends on spp_pkg and the design sources.
`default_nettype none

module tb import spp_pkg::*; ();

    localparam logic [2:0] CFG_IDX_LAST = 3'd7;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic [11:0]        scl;
        logic [11:0]        tw;
        logic [11:0]        th;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [11:0]        ang;
        logic signed [15:0] pit;
    } t_proj_req;

    typedef struct {
        logic               vis;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [15:0]        size;
        logic               sv;
        logic [15:0]        sx;
        logic [15:0]        sy;
    } t_proj_res;

    typedef struct {
        t_proj_req req;
        bit        typed;
        t_proj_res res;
    } t_dir_row;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    logic signed [23:0] i_object_x, i_object_y, i_camera_x, i_camera_y;
    logic [11:0] i_object_scale, i_texture_width, i_texture_height, i_camera_angle;
    logic signed [15:0] i_camera_pitch;
    logic o_out_valid, i_out_ready;
    logic o_visible, o_scale_valid;
    logic signed [15:0] o_sprite_left, o_sprite_top;
    logic [15:0] o_sprite_size, o_scale_x, o_scale_y;
    logic i_cfg_valid, o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [17:0] i_cfg_data;

    logic [11:0] scr_w, scr_h;
    logic [17:0] focal;
    logic [9:0]  gain;
    logic [15:0] near;

    t_proj_res pending_proj[$];
    t_dir_row  dir_rows[$];
    int errors = 0;
    int hold_cnt = 0;
    bit fast = 0;

    sprite_perspective_projection_top dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sine_q14(logic [11:0] n);
        longint x, x2, t, s;
        x = longint'(n[9:0]) << 4;
        if (n[10]) x = 16384 - x;
        x2 = (x * x) >>> 14;
        t = 21024 - ((x2 * 2320) >>> 14);
        t = 51472 - ((x2 * t) >>> 14);
        s = (x * t) >>> 15;
        return n[11] ? -s : s;
    endfunction

    function automatic t_proj_res project(t_proj_req r);
        t_proj_res o;
        logic [11:0] neg;
        longint rx, ry, sn, cs, d, e, size, half, xs, top;
        o = '{default: '0};
        rx = longint'(r.ox) - longint'(r.cx);
        ry = longint'(r.oy) - longint'(r.cy);
        neg = 12'd0 - r.ang;
        sn = sine_q14(neg);
        cs = sine_q14(neg + 12'd1024);
        d = rx * cs - ry * sn;
        e = rx * sn + ry * cs;
        if (d <= (longint'(near) <<< 14)) return o;
        size = fdiv((longint'(scr_h) * longint'(r.scl)) <<< 18, d);
        half = size >>> 1;
        xs = longint'(scr_w) * 8 + fdiv(e * longint'(focal), d * 16);
        top = longint'(scr_h) * 8 + ((longint'(r.pit) * longint'(gain)) >>> 10) - half;
        o.vis = 1;
        o.left = 16'(clampv(xs - half, -32768, 32767));
        o.top = 16'(clampv(top, -32768, 32767));
        o.size = 16'(clampv(size, 0, 65535));
        if (r.tw != 0 && r.th != 0) begin
            o.sv = 1;
            o.sx = 16'(clampv(size * 16 / longint'(r.tw), 0, 65535));
            o.sy = 16'(clampv(size * 16 / longint'(r.th), 0, 65535));
        end
        return o;
    endfunction

    function automatic t_proj_req mk(longint ox, longint oy, longint scl, longint tw,
                                     longint th, longint cx, longint cy, longint ang,
                                     longint pit);
        t_proj_req r;
        r.ox = 24'(ox); r.oy = 24'(oy); r.scl = 12'(scl); r.tw = 12'(tw); r.th = 12'(th);
        r.cx = 24'(cx); r.cy = 24'(cy); r.ang = 12'(ang); r.pit = 16'(pit);
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        if (fast) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_proj_req rand_req();
        t_proj_req r;
        r.cx = 24'($urandom); r.cy = 24'($urandom);
        if ($urandom_range(0, 99) < 60) begin
            r.ox = r.cx + 24'($signed(15'($urandom)));
            r.oy = r.cy + 24'($signed(15'($urandom)));
        end else begin
            r.ox = 24'($urandom); r.oy = 24'($urandom);
        end
        r.scl = 12'($urandom);
        r.tw = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom);
        r.th = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom);
        r.ang = 12'($urandom);
        r.pit = 16'($urandom);
        return r;
    endfunction

    task automatic send(t_proj_req r, bit typed, t_proj_res want);
        int g;
        g = idle_gap();
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_object_x <= r.ox; i_object_y <= r.oy; i_object_scale <= r.scl;
        i_texture_width <= r.tw; i_texture_height <= r.th;
        i_camera_x <= r.cx; i_camera_y <= r.cy;
        i_camera_angle <= r.ang; i_camera_pitch <= r.pit;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_proj.push_back(typed ? want : project(r));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [17:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
        case (idx)
            CFG_SCREEN_W: scr_w = val[11:0];
            CFG_SCREEN_H: scr_h = val[11:0];
            CFG_FOCAL:    focal = val;
            CFG_GAIN:     gain = val[9:0];
            CFG_NEAR:     near = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(longint w, longint h, longint f, longint g, longint n);
        write_reg(CFG_SCREEN_W, 18'(w));
        write_reg(CFG_SCREEN_H, 18'(h));
        write_reg(CFG_FOCAL, 18'(f));
        write_reg(CFG_GAIN, 18'(g));
        write_reg(CFG_NEAR, 18'(n));
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pending_proj.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_items(int n);
        repeat (n) send(rand_req(), 0, '{default: '0});
    endtask

    // result side: one ready assignment per edge
    initial begin
        int stall;
        stall = 0;
        i_out_ready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                i_out_ready <= 0;
                hold_cnt--;
            end else if (stall > 0) begin
                i_out_ready <= 0;
                stall--;
            end else begin
                i_out_ready <= 1;
                stall = idle_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_proj_res w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_proj.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = pending_proj.pop_front();
                if (o_visible !== w.vis) report("visible", o_visible, w.vis);
                if (o_sprite_left !== w.left) report("sprite_left", o_sprite_left, w.left);
                if (o_sprite_top !== w.top) report("sprite_top", o_sprite_top, w.top);
                if (o_sprite_size !== w.size) report("sprite_size", o_sprite_size, w.size);
                if (o_scale_valid !== w.sv) report("scale_valid", o_scale_valid, w.sv);
                if (o_scale_x !== w.sx) report("scale_x", o_scale_x, w.sx);
                if (o_scale_y !== w.sy) report("scale_y", o_scale_y, w.sy);
            end
        end
    end

    initial begin
        t_proj_res zero, ahead;
        zero = '{default: '0};
        ahead = '{vis: 1, left: 16'sd1600, top: 16'sd0, size: 16'd9600, sv: 1,
                  sx: 16'd9600, sy: 16'd4800};
        dir_rows.push_back('{mk(1000, -500, 256, 16, 16, 1000, -500, 0, 0), 1, zero});
        dir_rows.push_back('{mk(256, 0, 256, 16, 32, 0, 0, 0, 0), 1, ahead});
        dir_rows.push_back('{mk(26, 0, 256, 16, 16, 0, 0, 0, 0), 1, zero});
        dir_rows.push_back('{mk(27, 0, 4095, 1, 1, 0, 0, 0, 0), 0, zero});
        dir_rows.push_back('{mk(8388607, 0, 4095, 4095, 4095, -8388608, 0, 0, 0), 0, zero});
        dir_rows.push_back('{mk(-8388608, 0, 256, 16, 16, 8388607, 0, 0, 0), 1, zero});
        dir_rows.push_back('{mk(512, 8388607, 256, 16, 16, 0, -8388608, 0, 0), 0, zero});
        dir_rows.push_back('{mk(512, -8388608, 256, 16, 16, 0, 8388607, 0, 0), 0, zero});
        dir_rows.push_back('{mk(512, 0, 0, 16, 16, 0, 0, 0, 0), 0, zero});
        dir_rows.push_back('{mk(512, 0, 4095, 4095, 4095, 0, 0, 0, 0), 0, zero});
        dir_rows.push_back('{mk(512, 100, 256, 0, 16, 0, 0, 0, 0), 0, zero});
        dir_rows.push_back('{mk(512, 100, 256, 16, 0, 0, 0, 0, 0), 0, zero});
        dir_rows.push_back('{mk(512, 100, 256, 0, 0, 0, 0, 0, 0), 0, zero});
        dir_rows.push_back('{mk(0, 512, 256, 8, 8, 0, 0, 1024, 0), 0, zero});
        dir_rows.push_back('{mk(-512, 0, 256, 8, 8, 0, 0, 2048, 0), 0, zero});
        dir_rows.push_back('{mk(0, -512, 256, 8, 8, 0, 0, 3072, 0), 0, zero});
        dir_rows.push_back('{mk(512, 30, 256, 8, 8, 0, 0, 4095, 0), 0, zero});
        dir_rows.push_back('{mk(400, 77, 300, 8, 8, 0, 0, 512, 0), 0, zero});
        dir_rows.push_back('{mk(512, 0, 256, 8, 8, 0, 0, 0, 32767), 0, zero});
        dir_rows.push_back('{mk(512, 0, 256, 8, 8, 0, 0, 0, -32768), 0, zero});
        dir_rows.push_back('{mk(30, 8388607, 4095, 1, 1, 0, 0, 0, 0), 0, zero});

        scr_w = SCREEN_W_RST; scr_h = SCREEN_H_RST; focal = FOCAL_RST;
        gain = GAIN_RST; near = NEAR_RST;
        i_rst_n = 0; i_in_valid = 0; i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_object_x = '0; i_object_y = '0; i_object_scale = '0; i_texture_width = '0;
        i_texture_height = '0; i_camera_x = '0; i_camera_y = '0; i_camera_angle = '0;
        i_camera_pitch = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
        random_items(90);
        drain();

        write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 200));
        hold_cnt = HOLD_CYCLES;
        random_items(110);
        drain();

        write_all(4095, 4095, 262143, 1023, 65535);
        random_items(110);
        drain();

        write_all(1, 1, 1, 0, 1);
        random_items(110);
        drain();

        for (int idx = int'(CFG_NEAR) + 1; idx <= int'(CFG_IDX_LAST); idx++)
            write_reg(3'(idx), 18'($urandom));
        write_all($urandom, $urandom, $urandom, $urandom, 0);
        random_items(110);
        drain();

        write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 60));
        fast = 1;
        random_items(60);
        fast = 0;
        random_items(50);
        drain();

        write_all(SCREEN_W_RST, SCREEN_H_RST, FOCAL_RST, GAIN_RST, NEAR_RST);
        random_items(60);
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
